### hdl/tsb_pkg.sv
// Shared constants and types for the bilinear sparse texture sampler.
// Used by tsb_div, tsb_mem and texture_sampler_bilinear_sparse.
package tsb_pkg;

  localparam int MAX_SIDE     = 128;
  localparam int TEXEL_BITS   = 16;
  localparam int MAX_CHANNELS = 4;
  localparam int SIDE_BITS    = $clog2(MAX_SIDE);
  localparam int ADDR_BITS    = 2 * SIDE_BITS;
  localparam int WORD_BITS    = TEXEL_BITS * MAX_CHANNELS;
  localparam int CH_BITS      = 2;

  // Divider operand widths and step counter width.
  localparam int DVD_BITS  = 32;
  localparam int DVS_BITS  = 24;
  localparam int CNT_BITS  = $clog2(DVD_BITS + 1);

  // Stream word widths.
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  // Input word kinds carried on tuser.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX_MOD,
    ST_AX_MUL,
    ST_DIV_K,
    ST_DIV_W,
    ST_AX_MUL2,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_CORNER,
    ST_FETCH,
    ST_MIX,
    ST_OUT
  } state_t;

endpackage

### hdl/tsb_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on tsb_pkg for operand widths.
module tsb_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tsb_pkg::DVD_BITS-1:0] dividend,
  input  logic [tsb_pkg::DVS_BITS-1:0] divisor,
  output logic                         done,
  output logic [tsb_pkg::DVD_BITS-1:0] quot,
  output logic [tsb_pkg::DVS_BITS-1:0] rem
);

  logic                         busy;
  logic [tsb_pkg::CNT_BITS-1:0] cnt;
  logic [tsb_pkg::DVD_BITS-1:0] dvd;
  logic [tsb_pkg::DVS_BITS-1:0] r;
  logic [tsb_pkg::DVS_BITS-1:0] dvs;
  logic [tsb_pkg::DVS_BITS:0]   trial;
  logic                         fits;

  // Shift in the next dividend bit and test against the divisor.
  assign trial = {r, dvd[tsb_pkg::DVD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control: count the steps and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tsb_pkg::CNT_BITS'(tsb_pkg::DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tsb_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      r   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        r   <= tsb_pkg::DVS_BITS'(trial - {1'b0, dvs});
        dvd <= {dvd[tsb_pkg::DVD_BITS-2:0], 1'b1};
      end else begin
        r   <= trial[tsb_pkg::DVS_BITS-1:0];
        dvd <= {dvd[tsb_pkg::DVD_BITS-2:0], 1'b0};
      end
    end
  end

  assign quot = dvd;
  assign rem  = r;

endmodule

### hdl/tsb_mem.sv
// Texel store: one word of all channels per texel, single port,
// per-channel write, registered read. Depends on tsb_pkg.
module tsb_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [tsb_pkg::ADDR_BITS-1:0] addr,
  input  logic [tsb_pkg::CH_BITS-1:0]   wch,
  input  logic [tsb_pkg::TEXEL_BITS-1:0] wdata,
  output logic [tsb_pkg::WORD_BITS-1:0] rdata
);

  logic [tsb_pkg::WORD_BITS-1:0] mem [tsb_pkg::MAX_SIDE * tsb_pkg::MAX_SIDE];

  // Write one channel lane, or read the whole texel word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr][wch * tsb_pkg::TEXEL_BITS +: tsb_pkg::TEXEL_BITS] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/texture_sampler_bilinear_sparse.sv
// Bilinear sparse texture sampler: texel store, one shared divider, one multiplier
// and one shared blend unit under a sequencer. Depends on tsb_pkg, tsb_div, tsb_mem.
// Write words are taken back to back while the sequencer is idle. Nearest clamp
// samples are fastest and sparse bilinear repeat samples slowest; the divider, used
// up to ten times, and the blend unit, per group of four texels, set the time.
// Reset clears the sequencer and sets width, height and channels to 1; the store is
// undefined until written.
module texture_sampler_bilinear_sparse (
  input  logic                         clk,
  input  logic                         rst,
  // tdata: texel_x, texel_y, channel, texel_value, coord_u, coord_v, clamp_mode,
  //        linear_filter, sparse_mode, sector_divisor, zero fill
  input  logic [tsb_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,  // func
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // tdata: result_ch0, result_ch1, result_ch2, result_ch3
  output logic [tsb_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [7:0]                   cfg_data
);

  localparam int TB = tsb_pkg::TEXEL_BITS;

  // Input fields.
  logic [6:0]         in_x, in_y;
  logic [1:0]         in_ch;
  logic [15:0]        in_val;
  logic signed [23:0] in_u, in_v;
  logic               in_clamp, in_linear, in_sparse;
  logic [7:0]         in_div;

  assign in_x      = s_tdata[6:0];
  assign in_y      = s_tdata[13:7];
  assign in_ch     = s_tdata[15:14];
  assign in_val    = s_tdata[31:16];
  assign in_u      = s_tdata[55:32];
  assign in_v      = s_tdata[79:56];
  assign in_clamp  = s_tdata[80];
  assign in_linear = s_tdata[81];
  assign in_sparse = s_tdata[82];
  assign in_div    = s_tdata[90:83];

  // Blend: a + floor(((b - a) * f + 2^15) / 2^16).
  function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                      input logic [15:0] f);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] q;
    diff = $signed({b[15], b}) - $signed({a[15], a});
    prod = diff * $signed({1'b0, f});
    q    = (prod + 34'sd32768) >>> 16;
    return a + q[15:0];
  endfunction

  // Map a Q.16 position into [0, size): clamp to edge, or one wrap step.
  function automatic logic [23:0] fold(input logic signed [33:0] p, input logic [7:0] size,
                                       input logic clamp);
    logic signed [33:0] m;
    logic signed [33:0] top;
    logic [7:0]         sm1;
    sm1 = size - 8'd1;
    m   = $signed({10'b0, size, 16'b0});
    top = $signed({10'b0, sm1, 16'b0});
    if (clamp) begin
      if (p < 0) return '0;
      else if (p > top) return top[23:0];
      else return p[23:0];
    end else begin
      if (p >= m) return 24'(p - m);
      else return p[23:0];
    end
  endfunction

  function automatic logic [7:0] eff_side(input logic [7:0] r);
    if (r == 8'd0) return 8'd1;
    else if (r > 8'(tsb_pkg::MAX_SIDE)) return 8'(tsb_pkg::MAX_SIDE);
    else return r;
  endfunction

  function automatic logic [15:0] lane(input logic [63:0] w, input logic [1:0] c);
    return w[{c, 4'b0} +: TB];
  endfunction

  // Configuration registers.
  logic [7:0] width_reg, height_reg;
  logic [2:0] chan_reg;
  logic [7:0] sz_w, sz_h;
  logic [2:0] nch;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 8'd1;
      height_reg <= 8'd1;
      chan_reg   <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsb_pkg::REG_WIDTH:    width_reg  <= cfg_data;
        tsb_pkg::REG_HEIGHT:   height_reg <= cfg_data;
        tsb_pkg::REG_CHANNELS: chan_reg   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign sz_w = eff_side(width_reg);
  assign sz_h = eff_side(height_reg);
  assign nch  = (chan_reg == 3'd0) ? 3'd1 :
                ((chan_reg > 3'(tsb_pkg::MAX_CHANNELS)) ? 3'(tsb_pkg::MAX_CHANNELS) : chan_reg);

  // Sequencer and working registers.
  tsb_pkg::state_t state, state_next;

  logic               clamp_q, linear_q, sparse_q;
  logic [7:0]         d_q;
  logic signed [31:0] pos [2];
  logic [23:0]        cx [2];
  logic [15:0]        wt [2];
  logic [23:0]        lo [2];
  logic [23:0]        hi [2];
  logic [7:0]         kq;
  logic [23:0]        remq;
  logic [31:0]        prod;
  logic               ax;
  logic [1:0]         j;
  logic [6:0]         x0, x1, y0, y1;
  logic [15:0]        fa, fb;
  logic [2:0]         fcnt;
  logic [63:0]        tex [4];
  logic [63:0]        corner [3];
  logic [63:0]        acc;
  logic [15:0]        t1, t2;
  logic [1:0]         ch, step;
  logic               fin;
  logic [63:0]        res;
  logic               div_wait;

  // Divider hookup.
  logic        div_go, div_done;
  logic [31:0] div_dvd, div_q;
  logic [23:0] div_dvs, div_r;

  logic [7:0]         sz_a;
  logic [23:0]        m_a;
  logic signed [31:0] pos_a;
  logic [31:0]        pos_abs;

  assign sz_a    = ax ? sz_h : sz_w;
  assign m_a     = {sz_a, 16'b0};
  assign pos_a   = pos[ax];
  assign pos_abs = pos_a[31] ? 32'(-pos_a) : 32'(pos_a);

  always_comb begin
    unique case (state)
      tsb_pkg::ST_DIV_K:  begin div_dvd = prod;          div_dvs = m_a;          end
      tsb_pkg::ST_DIV_W:  begin div_dvd = {8'b0, remq};  div_dvs = {16'b0, sz_a}; end
      tsb_pkg::ST_DIV_LO: begin div_dvd = prod;          div_dvs = {16'b0, d_q}; end
      tsb_pkg::ST_DIV_HI: begin div_dvd = prod + {8'b0, m_a}; div_dvs = {16'b0, d_q}; end
      default:            begin div_dvd = pos_abs;       div_dvs = m_a;          end
    endcase
  end

  assign div_go = !div_wait && ((state == tsb_pkg::ST_AX_MOD && !clamp_q) ||
                  state == tsb_pkg::ST_DIV_K || state == tsb_pkg::ST_DIV_W ||
                  state == tsb_pkg::ST_DIV_LO || state == tsb_pkg::ST_DIV_HI);

  tsb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // Shared multiplier for s = cx * d and k * span.
  logic [23:0] mul_a;
  logic [7:0]  mul_b;
  assign mul_a = (state == tsb_pkg::ST_AX_MUL) ? cx[ax] : m_a;
  assign mul_b = (state == tsb_pkg::ST_AX_MUL) ? d_q : kq;

  // Corner setup: texel indices and fractions on both axes.
  logic signed [33:0] px, py;
  logic [23:0]        c0x, c1x, c0y, c1y;
  always_comb begin
    px  = sparse_q ? $signed({10'b0, (j[0] ? hi[0] : lo[0])}) : 34'(pos[0]);
    py  = sparse_q ? $signed({10'b0, (j[1] ? hi[1] : lo[1])}) : 34'(pos[1]);
    c0x = sparse_q ? fold(px, sz_w, clamp_q) : cx[0];
    c0y = sparse_q ? fold(py, sz_h, clamp_q) : cx[1];
    c1x = fold(clamp_q ? px + 34'sd65536 : $signed({10'b0, c0x}) + 34'sd65536,
               sz_w, clamp_q);
    c1y = fold(clamp_q ? py + 34'sd65536 : $signed({10'b0, c0y}) + 34'sd65536,
               sz_h, clamp_q);
  end

  // Texel store.
  logic [2:0]                    nfetch;
  logic [2:0]                    fidx;
  logic                          mem_we, mem_re;
  logic [tsb_pkg::ADDR_BITS-1:0] mem_addr;
  logic [63:0]                   mem_rdata;

  assign nfetch = linear_q ? 3'd4 : 3'd1;
  assign fidx   = fcnt - 3'd1;
  assign mem_we = s_tvalid && s_tready && (s_tuser == tsb_pkg::FUNC_WRITE);
  assign mem_re = (state == tsb_pkg::ST_FETCH) && (fcnt < nfetch);
  assign mem_addr = (state == tsb_pkg::ST_IDLE) ? {in_y, in_x} :
                    {(fcnt[1] ? y1 : y0), (fcnt[0] ? x1 : x0)};

  tsb_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wch   (in_ch),
    .wdata (in_val),
    .rdata (mem_rdata)
  );

  // Blend unit operands.
  logic [15:0] mix_a, mix_b, mix_f, mix_o;
  always_comb begin
    case (step)
      2'd0:    begin mix_a = lane(tex[0], ch); mix_b = lane(tex[1], ch); end
      2'd1:    begin mix_a = lane(tex[2], ch); mix_b = lane(tex[3], ch); end
      default: begin mix_a = t1;              mix_b = t2;              end
    endcase
    mix_f = (step == 2'd2) ? fb : fa;
  end
  assign mix_o = mix(mix_a, mix_b, mix_f);

  // End-of-group events and the word a finished group produced.
  logic        fetch_end, mix_end, grp_end, sample_end;
  logic [63:0] grp_word;
  assign fetch_end  = (state == tsb_pkg::ST_FETCH) && (fcnt == nfetch);
  assign mix_end    = (state == tsb_pkg::ST_MIX) && (step == 2'd2) && (ch == 2'd3);
  assign grp_end    = (fetch_end && !linear_q) || (mix_end && !fin);
  assign sample_end = mix_end && fin;
  assign grp_word   = (state == tsb_pkg::ST_FETCH) ? mem_rdata : {mix_o, acc[47:0]};

  logic ax_end, out_free;
  assign ax_end   = (state == tsb_pkg::ST_AX_MOD) && (clamp_q || div_done);
  assign out_free = !m_tvalid || m_tready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state) inside
      tsb_pkg::ST_IDLE:
        if (s_tvalid && s_tuser == tsb_pkg::FUNC_SAMPLE) state_next = tsb_pkg::ST_AX_MOD;
      tsb_pkg::ST_AX_MOD:
        if (ax_end) begin
          if (sparse_q) state_next = tsb_pkg::ST_AX_MUL;
          else state_next = ax ? tsb_pkg::ST_CORNER : tsb_pkg::ST_AX_MOD;
        end
      tsb_pkg::ST_AX_MUL:  state_next = tsb_pkg::ST_DIV_K;
      tsb_pkg::ST_DIV_K:   if (div_done) state_next = tsb_pkg::ST_DIV_W;
      tsb_pkg::ST_DIV_W:   if (div_done) state_next = tsb_pkg::ST_AX_MUL2;
      tsb_pkg::ST_AX_MUL2: state_next = tsb_pkg::ST_DIV_LO;
      tsb_pkg::ST_DIV_LO:  if (div_done) state_next = tsb_pkg::ST_DIV_HI;
      tsb_pkg::ST_DIV_HI:
        if (div_done) state_next = ax ? tsb_pkg::ST_CORNER : tsb_pkg::ST_AX_MOD;
      tsb_pkg::ST_CORNER:  state_next = tsb_pkg::ST_FETCH;
      tsb_pkg::ST_FETCH, tsb_pkg::ST_MIX: begin
        if (fetch_end && linear_q) state_next = tsb_pkg::ST_MIX;
        else if (sample_end) state_next = tsb_pkg::ST_OUT;
        else if (grp_end) begin
          if (!sparse_q) state_next = tsb_pkg::ST_OUT;
          else if (j == 2'd3) state_next = tsb_pkg::ST_MIX;
          else state_next = tsb_pkg::ST_CORNER;
        end
      end
      tsb_pkg::ST_OUT:     if (out_free) state_next = tsb_pkg::ST_IDLE;
      default:             state_next = tsb_pkg::ST_IDLE;
    endcase
  end

  // Divider handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_wait <= 1'b0;
    end else if (div_go) begin
      div_wait <= 1'b1;
    end else if (div_done) begin
      div_wait <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state) inside
      tsb_pkg::ST_IDLE: begin
        clamp_q  <= in_clamp;
        linear_q <= in_linear;
        sparse_q <= in_sparse;
        d_q      <= (in_div == 8'd0) ? 8'd1 : in_div;
        pos[0]   <= 32'(in_u * $signed({1'b0, sz_w}));
        pos[1]   <= 32'(in_v * $signed({1'b0, sz_h}));
        ax       <= 1'b0;
        j        <= 2'd0;
      end
      tsb_pkg::ST_AX_MOD: begin
        if (clamp_q) begin
          cx[ax] <= fold(34'(pos_a), sz_a, 1'b1);
        end else if (div_done) begin
          cx[ax] <= (pos_a[31] && div_r != 24'd0) ? m_a - div_r : div_r;
        end
        if (ax_end && !sparse_q) ax <= 1'b1;
      end
      tsb_pkg::ST_AX_MUL, tsb_pkg::ST_AX_MUL2: begin
        prod <= 32'(mul_a * mul_b);
      end
      tsb_pkg::ST_DIV_K: begin
        if (div_done) begin
          kq   <= div_q[7:0];
          remq <= div_r;
        end
      end
      tsb_pkg::ST_DIV_W: begin
        if (div_done) wt[ax] <= div_q[15:0];
      end
      tsb_pkg::ST_DIV_LO: begin
        if (div_done) lo[ax] <= div_q[23:0];
      end
      tsb_pkg::ST_DIV_HI: begin
        if (div_done) begin
          hi[ax] <= div_q[23:0];
          ax     <= 1'b1;
        end
      end
      tsb_pkg::ST_CORNER: begin
        x0   <= c0x[22:16];
        x1   <= c1x[22:16];
        y0   <= c0y[22:16];
        y1   <= c1y[22:16];
        fa   <= c0x[15:0];
        fb   <= c0y[15:0];
        fin  <= 1'b0;
        fcnt <= 3'd0;
        ch   <= 2'd0;
        step <= 2'd0;
      end
      tsb_pkg::ST_FETCH: begin
        // Nearest groups take the read word directly, so only bilinear fills tex.
        if (linear_q && fcnt != 3'd0) tex[fidx[1:0]] <= mem_rdata;
        if (fcnt != nfetch) fcnt <= fcnt + 3'd1;
      end
      tsb_pkg::ST_MIX: begin
        case (step)
          2'd0:    t1 <= mix_o;
          2'd1:    t2 <= mix_o;
          default: acc[{ch, 4'b0} +: TB] <= mix_o;
        endcase
        if (step == 2'd2) begin
          step <= 2'd0;
          ch   <= ch + 2'd1;
        end else begin
          step <= step + 2'd1;
        end
      end
      default: ;
    endcase

    // A finished group becomes a result, a sector corner, or the final blend input.
    // Channel and step counters return to zero as a bilinear group ends.
    if (sample_end) begin
      res <= grp_word;
    end else if (grp_end) begin
      if (!sparse_q) begin
        res <= grp_word;
      end else if (j == 2'd3) begin
        tex[0] <= corner[0];
        tex[1] <= corner[1];
        tex[2] <= corner[2];
        tex[3] <= grp_word;
        fa     <= wt[0];
        fb     <= wt[1];
        fin    <= 1'b1;
      end else begin
        corner[j] <= grp_word;
        j         <= j + 2'd1;
      end
    end
  end

  // Output register; channels beyond the count in use read as zero.
  logic [63:0] out_word;
  always_comb begin
    for (int c = 0; c < tsb_pkg::MAX_CHANNELS; c++) begin
      out_word[c*TB +: TB] = (3'(c) < nch) ? res[c*TB +: TB] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == tsb_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tsb_pkg::ST_OUT && out_free) m_tdata <= out_word;
  end

  assign s_tready = (state == tsb_pkg::ST_IDLE);

`ifndef SYNTH
  a_sample_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> (state != tsb_pkg::ST_IDLE))
    else $error("sample word did not start the sequencer");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == tsb_pkg::ST_OUT && m_tvalid && !m_tready) |=> (state == tsb_pkg::ST_OUT))
    else $error("result overwrote a word still waiting");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == tsb_pkg::ST_OUT))
    else $error("result word appeared outside the output step");

  a_div_single: assert property (@(posedge clk) disable iff (rst)
    div_go |=> !div_go)
    else $error("divider started twice");
`endif

endmodule

### verif/texture_sampler_bilinear_sparse_test.sv
// Self-checking test of texture_sampler_bilinear_sparse: texel writes, nearest,
// bilinear and sparse samples under repeat and clamp, with random stalls on both streams.
// Depends on tsb_pkg and the sampler RTL only.
`timescale 1ns / 1ps

module texture_sampler_bilinear_sparse_test;

  typedef longint chan4_t[4];

  // Holds a copy of the texel store and registers and predicts each sample word.
  class texel_scoreboard;
    logic signed [15:0] texels[tsb_pkg::MAX_SIDE*tsb_pkg::MAX_SIDE][tsb_pkg::MAX_CHANNELS];
    logic [7:0] width_reg = 8'd1;
    logic [7:0] height_reg = 8'd1;
    logic [2:0] chan_reg = 3'd1;
    logic [tsb_pkg::M_DATA_W-1:0] results_due[$];
    int errors = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == tsb_pkg::REG_WIDTH) width_reg = val;
      else if (idx == tsb_pkg::REG_HEIGHT) height_reg = val;
      else if (idx == tsb_pkg::REG_CHANNELS) chan_reg = val[2:0];
    endfunction

    function longint side(logic [7:0] r);
      if (r == 0) return 1;
      if (r > tsb_pkg::MAX_SIDE) return tsb_pkg::MAX_SIDE;
      return longint'(r);
    endfunction

    function int chans();
      if (chan_reg == 0) return 1;
      if (chan_reg > tsb_pkg::MAX_CHANNELS) return tsb_pkg::MAX_CHANNELS;
      return int'(chan_reg);
    endfunction

    function longint floor16(longint x);
      if (x >= 0) return x >>> 16;
      return -(((-x) + 65535) >>> 16);
    endfunction

    function longint blend(longint a, longint b, longint f);
      return a + floor16((b - a) * f + 32768);
    endfunction

    // Bring a Q.16 texel-space position into [0, size).
    function longint wrap_pos(longint p, longint size, bit clamp);
      longint m;
      m = size << 16;
      if (clamp) begin
        if (p < 0) return 0;
        if (p > ((size - 1) << 16)) return (size - 1) << 16;
        return p;
      end
      p = p % m;
      if (p < 0) p += m;
      return p;
    endfunction

    function longint texel_at(longint x, longint y, int c);
      return longint'(texels[(y * tsb_pkg::MAX_SIDE + x) %
                             (tsb_pkg::MAX_SIDE * tsb_pkg::MAX_SIDE)][c]);
    endfunction

    function void plain_sample(longint px, longint py, bit clamp, bit linear,
                               output chan4_t r);
      longint w, h, cx, cy, x0, y0, x1, y1, top, bot;
      w = side(width_reg);
      h = side(height_reg);
      cx = wrap_pos(px, w, clamp);
      cy = wrap_pos(py, h, clamp);
      x0 = cx >>> 16;
      y0 = cy >>> 16;
      x1 = wrap_pos(px + 65536, w, clamp) >>> 16;
      y1 = wrap_pos(py + 65536, h, clamp) >>> 16;
      for (int c = 0; c < 4; c++) r[c] = 0;
      for (int c = 0; c < chans(); c++) begin
        if (!linear) begin
          r[c] = texel_at(x0, y0, c);
        end else begin
          top = blend(texel_at(x0, y0, c), texel_at(x1, y0, c), cx & 16'hFFFF);
          bot = blend(texel_at(x0, y1, c), texel_at(x1, y1, c), cx & 16'hFFFF);
          r[c] = blend(top, bot, cy & 16'hFFFF);
        end
      end
    endfunction

    // Sector corners and sector weight along one axis.
    function void sector_split(longint p, longint size, longint d, bit clamp,
                               output longint lo, output longint hi, output longint wt);
      longint s, span, k;
      s = wrap_pos(p, size, clamp) * d;
      span = size << 16;
      k = s / span;
      wt = (s - k * span) / size;
      lo = (k * span) / d;
      hi = ((k + 1) * span) / d;
    endfunction

    function void note_word(logic func, logic [tsb_pkg::S_DATA_W-1:0] d);
      longint u, v, w, h, dv, lx, hx, wx, ly, hy, wy, r;
      chan4_t res, lt, rt, lb, rb;
      bit clamp, linear;
      logic [tsb_pkg::M_DATA_W-1:0] packed_res;
      if (func == tsb_pkg::FUNC_WRITE) begin
        texels[{d[13:7], d[6:0]}][d[15:14]] = d[31:16];
        return;
      end
      u = longint'($signed(d[55:32]));
      v = longint'($signed(d[79:56]));
      clamp = d[80];
      linear = d[81];
      w = side(width_reg);
      h = side(height_reg);
      if (d[82]) begin
        dv = (d[90:83] == 8'd0) ? 1 : longint'(d[90:83]);
        sector_split(u * w, w, dv, clamp, lx, hx, wx);
        sector_split(v * h, h, dv, clamp, ly, hy, wy);
        plain_sample(lx, ly, clamp, linear, lt);
        plain_sample(lx, hy, clamp, linear, lb);
        plain_sample(hx, hy, clamp, linear, rb);
        plain_sample(hx, ly, clamp, linear, rt);
        for (int c = 0; c < 4; c++)
          res[c] = blend(blend(lt[c], rt[c], wx), blend(lb[c], rb[c], wx), wy);
      end else begin
        plain_sample(u * w, v * h, clamp, linear, res);
      end
      for (int c = 0; c < 4; c++) begin
        r = (c < chans()) ? res[c] : 0;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        packed_res[16*c +: 16] = r[15:0];
      end
      results_due.push_back(packed_res);
    endfunction

    function void check_word(logic [tsb_pkg::M_DATA_W-1:0] got);
      logic [tsb_pkg::M_DATA_W-1:0] want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      for (int c = 0; c < 4; c++)
        if (got[16*c +: 16] !== want[16*c +: 16]) begin
          $display("%0t: result_ch%0d expected %0d actual %0d", $time, c,
                   $signed(want[16*c +: 16]), $signed(got[16*c +: 16]));
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic [tsb_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [tsb_pkg::M_DATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  texel_scoreboard sb = new();
  bit written[tsb_pkg::MAX_SIDE*tsb_pkg::MAX_SIDE][tsb_pkg::MAX_CHANNELS];
  int idle_cycles = 0;
  bit rx_calm = 0;
  int rx_hold = 0;

  texture_sampler_bilinear_sparse dut (.*);

  initial forever #5 clk = ~clk;

  // Scoreboard taps on both streams.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side backpressure: calm stretches, short stalls and a few long ones.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_calm = ~rx_calm;
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready = 0;
    end else if (rx_calm) begin
      m_tready = 1;
    end else if ($urandom_range(0, 49) == 0) begin
      rx_hold = $urandom_range(20, 60);
      m_tready = 0;
    end else begin
      m_tready = ($urandom_range(0, 2) != 0);
    end
  end

  function automatic logic [tsb_pkg::S_DATA_W-1:0] pack_word(logic [6:0] x, logic [6:0] y,
      logic [1:0] ch, logic [15:0] val, logic [23:0] u, logic [23:0] v,
      logic cl, logic li, logic sp, logic [7:0] dv);
    return {5'd0, dv, sp, li, cl, v, u, val, ch, y, x};
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 65535));
      1: return 24'($urandom);
      2: return 24'(-$urandom_range(0, 65536 * 3));
      3: return 24'($urandom_range(0, 65536 * 4));
      4: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
      default: return 24'(65536 * $urandom_range(0, 3) - 1 + $urandom_range(0, 2));
    endcase
  endfunction

  // Push one word onto the input stream after a random gap.
  task automatic send_word(logic func, logic [tsb_pkg::S_DATA_W-1:0] d, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = func;
    s_tdata = d;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_texel(int x, int y, int ch, logic [15:0] val);
    logic [tsb_pkg::S_DATA_W-1:0] d;
    d = {$urandom, $urandom, $urandom};
    d[6:0] = 7'(x);
    d[13:7] = 7'(y);
    d[15:14] = 2'(ch);
    d[31:16] = val;
    written[y * tsb_pkg::MAX_SIDE + x][ch] = 1;
    send_word(tsb_pkg::FUNC_WRITE, d);
  endtask

  task automatic sample_at(logic [23:0] u, logic [23:0] v, bit cl, bit li, bit sp,
                           logic [7:0] dv);
    logic [31:0] junk;
    junk = $urandom;
    send_word(tsb_pkg::FUNC_SAMPLE, pack_word(junk[6:0], junk[13:7], junk[15:14],
                                              junk[31:16], u, v, cl, li, sp, dv));
  endtask

  // Wait for every predicted result, then let the block settle.
  task automatic drain();
    s_tvalid = 0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, val);
  endtask

  // Write every texel channel inside the image that has no value yet.
  task automatic fill_image();
    for (int y = 0; y < sb.side(sb.height_reg); y++)
      for (int x = 0; x < sb.side(sb.width_reg); x++)
        for (int c = 0; c < sb.chans(); c++)
          if (!written[y * tsb_pkg::MAX_SIDE + x][c]) write_texel(x, y, c, 16'($urandom));
  endtask

  task automatic random_items(int count);
    logic [7:0] dv;
    int x, y;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          x = $urandom_range(0, 127);
          y = $urandom_range(0, 127);
          write_texel(x, y, $urandom_range(0, 3), 16'($urandom));
        end
        1: write_texel($urandom_range(0, sb.side(sb.width_reg) - 1),
                       $urandom_range(0, sb.side(sb.height_reg) - 1),
                       $urandom_range(0, sb.chans() - 1), 16'($urandom));
        default: begin
          case ($urandom_range(0, 3))
            0: dv = 0;
            1: dv = 8'($urandom);
            default: dv = 8'($urandom_range(1, 6));
          endcase
          sample_at(rand_coord(), rand_coord(), 1'($urandom), 1'($urandom), 1'($urandom),
                    dv);
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] widths[8] = '{7, 128, 1, 0, 128, 3, 200, 6};
    logic [7:0] heights[8] = '{5, 1, 128, 200, 2, 3, 1, 9};
    logic [7:0] chan_set[8] = '{3, 4, 2, 5, 1, 0, 7, 4};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    for (int p = 0; p < 8; p++) begin
      set_reg(tsb_pkg::REG_WIDTH, widths[p]);
      set_reg(tsb_pkg::REG_HEIGHT, heights[p]);
      set_reg(tsb_pkg::REG_CHANNELS, chan_set[p]);
      if (p == 3) set_reg(2'd3, 8'hA5);
      fill_image();
      if (p == 0) begin
        // Value extremes, then every mode combination at corner coordinates.
        write_texel(0, 0, 0, 16'h7FFF);
        write_texel(6, 4, 0, 16'h8000);
        write_texel(1, 0, 1, 16'h8000);
        write_texel(0, 1, 2, 16'h7FFF);
        for (int m = 0; m < 8; m++)
          sample_at(m[0] ? 24'h7FFFFF : 24'h0, m[1] ? 24'h800000 : 24'h8000,
                    m[0], m[1], m[2], m[2] ? 8'd0 : 8'd3);
        sample_at(24'hFFFFFF, 24'h00FFFF, 0, 1, 0, 8'd0);
        sample_at(24'h010000, 24'hFF0000, 1, 1, 0, 8'd0);
        sample_at(24'h00C000, 24'h004000, 0, 1, 1, 8'd255);
        sample_at(24'h00C000, 24'h004000, 1, 0, 1, 8'd255);
        sample_at(24'h123456, 24'h00A000, 0, 1, 1, 8'd2);
        sample_at(24'h800000, 24'h7FFFFF, 1, 1, 1, 8'd1);
        // Hold the stream until the block has emptied out.
        s_tvalid = 0;
        while (sb.results_due.size() != 0) @(negedge clk);
      end
      random_items(p == 0 ? 60 : 75);
      if (p == 4) begin
        drain();
        random_items(40);
      end
      drain();
    end

    s_tvalid = 0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
